// File: rtl/qnrf_pkg.sv
// qnrf_pkg: types and constants for the quartic newton root finder
// no dependencies
`timescale 1ns / 1ps
package qnrf_pkg;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int COEF_WIDTH_DEF = 16;
   localparam int ITER_LIMIT_DEF = 64;
   localparam int VAL_W = 32;
   localparam int EPS_W = 31;
   localparam int MAXI_W = 7;
   localparam int IDX_W = 6;
   localparam int GUESS_W = 16;
   localparam int ADDR_W = 5;

   localparam logic [1:0] ST_RUNNING  = 2'd0;
   localparam logic [1:0] ST_CONVERGED = 2'd1;
   localparam logic [1:0] ST_LIMIT    = 2'd2;
   localparam logic [1:0] ST_ZERO_DER = 2'd3;

   localparam logic [2:0] REG_COEF_4 = 3'd4;
   localparam logic [2:0] REG_EPSILON = 3'd5;
   localparam logic [2:0] REG_MAX_ITER = 3'd6;

   typedef enum logic [3:0] {
      S_IDLE, S_PREP, S_ITER, S_FMUL, S_FADD, S_DMUL, S_DADD,
      S_DIVSTART, S_DIV, S_QUOT, S_STEP, S_OUT
   } state_type;

   // saturate a 66-bit signed value to 32 bits
   function automatic logic [32:0] sat32(input logic signed [65:0] v);
      logic [32:0] r;
      if (v > 66'sd2147483647) r = {1'b1, 32'h7fffffff};
      else if (v < -66'sd2147483648) r = {1'b1, 32'h80000000};
      else r = {1'b0, v[31:0]};
      return r;
   endfunction
endpackage

// File: rtl/quartic_newton_root_finder.sv
// quartic_newton_root_finder: newton-raphson root search on a quartic, q16.16 fixed point
// depends on qnrf_pkg
`timescale 1ns / 1ps
//  channel | direction | contents
//  req_    | in        | tdata: start_guess[15:0]
//  rsp_    | out       | tdata: iteration_index[5:0], estimate[37:6]; tuser status, saturated
//  csr_    | apb       | coef_0..coef_4, epsilon, max_iterations at 4*i
//
// one request runs up to max_iterations iterations (zero acts as one, capped at ITER_LIMIT),
// after a prep state; each iteration runs horner multiply/add steps on the single shared
// multiplier, the bit-serial restoring divider (load, 64 shifts, quotient), then status and
// output states; a zero derivative skips the divider and ends the request
// reset clears control and registers to their reset values
// req_tready is low while a request is in work; a stalled rsp_ holds the sequencer
module quartic_newton_root_finder import qnrf_pkg::*; #(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int COEF_WIDTH = COEF_WIDTH_DEF,
   parameter int ITER_LIMIT = ITER_LIMIT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // start_guess
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [39:0]           rsp_tdata,   // iteration_index[5:0], estimate[37:6], zero pad
   output logic [2:0]            rsp_tuser,   // status[1:0], saturated[2]
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   localparam int DIV_N = 64;  // dividend bits (f << FRAC_BITS fits in 64)
   localparam int CNT_W = $clog2(DIV_N + 1);

   logic [COEF_WIDTH-1:0] coef_ff [5];
   logic [EPS_W-1:0]  eps_ff;
   logic [MAXI_W-1:0] maxi_ff;

   state_type state_ff, state_in;
   logic signed [31:0] x_ff, x_in, acc_ff, acc_in, f_ff, f_in;
   logic signed [65:0] prod_ff, prod_in;
   logic [2:0]  step_ff, step_in;       // horner position
   logic [MAXI_W-1:0] cnt_ff, cnt_in, lim_ff, lim_in;
   logic clamp_ff, clamp_in;
   // divider
   logic [63:0] dq_ff, dq_in;           // dividend shifting to quotient
   logic [63:0] rem_ff, rem_in;
   logic [31:0] dv_ff, dv_in;           // |d|
   logic qneg_ff, qneg_in;
   logic [CNT_W-1:0] dcnt_ff, dcnt_in;
   // output register
   logic [5:0] o_idx_ff, o_idx_in;
   logic [31:0] o_est_ff, o_est_in;
   logic [1:0] o_st_ff, o_st_in;
   logic o_sat_ff, o_sat_in, o_last_ff, o_last_in;

   // register write
   logic wr;
   logic [2:0] widx;
   assign wr = csr_psel & csr_penable & csr_pwrite;
   assign widx = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 5; k++) coef_ff[k] <= '0;
         eps_ff  <= EPS_W'(66);
         maxi_ff <= MAXI_W'(64);
      end else if (wr && csr_paddr[1:0] == 2'b00) begin
         if (widx <= REG_COEF_4) coef_ff[widx] <= csr_pwdata[COEF_WIDTH-1:0];
         else if (widx == REG_EPSILON) eps_ff <= csr_pwdata[EPS_W-1:0];
         else if (widx == REG_MAX_ITER) maxi_ff <= csr_pwdata[MAXI_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (widx <= REG_COEF_4)
         csr_prdata = 32'(signed'(coef_ff[widx]));
      else if (widx == REG_EPSILON) csr_prdata = 32'(eps_ff);
      else if (widx == REG_MAX_ITER) csr_prdata = 32'(maxi_ff);
   end

   // scaled coefficient for horner step: f uses fc[4..0], d uses k*c[k] for k 4..1
   logic signed [65:0] craw;
   logic [32:0] cfix;
   logic dmode;
   assign dmode = (state_ff == S_DMUL) || (state_ff == S_DADD);
   always_comb begin
      logic signed [65:0] c;
      c = 66'(signed'(coef_ff[step_ff]));
      if (dmode) c = c * 66'(step_ff);
      craw = c <<< FRAC_BITS;
      cfix = sat32(craw);
   end

   // shared multiplier input and saturating adder
   logic signed [65:0] mul_p, fsh, sum;
   logic [32:0] ps, ss;
   assign mul_p = 66'(acc_ff) * 66'(x_ff);
   assign fsh = prod_ff >>> FRAC_BITS;   // arithmetic shift floors
   assign ps = sat32(fsh);
   assign sum = 66'(signed'(ps[31:0])) + 66'(signed'(cfix[31:0]));
   assign ss = sat32(sum);

   // divider trial
   logic [64:0] trial;
   assign trial = {rem_ff, dq_ff[63]} - {33'd0, dv_ff};

   // quotient and new estimate
   logic signed [65:0] qv, nxv, diff;
   logic [32:0] qs, nxs;
   logic [31:0] stepmag;
   always_comb begin
      qv = qneg_ff ? -$signed({2'b00, dq_ff}) : $signed({2'b00, dq_ff});
      qs = sat32(qv);
      nxv = 66'(x_ff) - 66'(signed'(qs[31:0]));
      nxs = sat32(nxv);
      diff = 66'(signed'(nxs[31:0])) - 66'(x_ff);
      stepmag = diff[65] ? 32'(-diff) : 32'(diff);
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata = {2'b00, o_est_ff, o_idx_ff};
   assign rsp_tuser = {o_sat_ff, o_st_ff};
   assign rsp_tlast = o_last_ff;

   always_comb begin
      logic signed [65:0] gs;
      logic [32:0] gsat;
      logic signed [31:0] dabs;
      state_in = state_ff; x_in = x_ff; acc_in = acc_ff; f_in = f_ff;
      prod_in = prod_ff; step_in = step_ff; cnt_in = cnt_ff; lim_in = lim_ff;
      clamp_in = clamp_ff; dq_in = dq_ff; rem_in = rem_ff; dv_in = dv_ff;
      qneg_in = qneg_ff; dcnt_in = dcnt_ff; o_idx_in = o_idx_ff;
      o_est_in = o_est_ff; o_st_in = o_st_ff; o_sat_in = o_sat_ff;
      o_last_in = o_last_ff;
      gs = 66'(signed'(req_tdata)) <<< FRAC_BITS;
      gsat = sat32(gs);
      dabs = '0;
      case (state_ff)
         S_IDLE: if (req_tvalid) begin
            x_in = gsat[31:0];
            clamp_in = gsat[32];
            cnt_in = '0;
            if (maxi_ff == '0) lim_in = MAXI_W'(1);
            else if (maxi_ff > MAXI_W'(ITER_LIMIT)) lim_in = MAXI_W'(ITER_LIMIT);
            else lim_in = maxi_ff;
            state_in = S_PREP;
         end
         S_PREP: begin
            // every coefficient is visited in the first iteration, so any
            // coefficient clamp is flagged before the first result
            step_in = 3'd4;
            state_in = S_ITER;
         end
         S_ITER: begin
            acc_in = cfix[31:0];   // f start: fc[4]
            clamp_in = clamp_ff | cfix[32];
            step_in = 3'd3;
            state_in = S_FMUL;
         end
         S_FMUL: begin
            prod_in = mul_p;
            state_in = S_FADD;
         end
         S_FADD: begin
            acc_in = ss[31:0];
            clamp_in = clamp_ff | ps[32] | ss[32] | cfix[32];
            if (step_ff == 3'd0) begin
               f_in = ss[31:0];
               step_in = 3'd4;
               state_in = S_DMUL;
               prod_in = '0;
            end else begin
               step_in = step_ff - 3'd1;
               state_in = S_FMUL;
            end
         end
         S_DMUL: begin
            if (step_ff == 3'd4) begin
               acc_in = cfix[31:0];
               clamp_in = clamp_ff | cfix[32];
               step_in = 3'd3;
            end else begin
               prod_in = mul_p;
               state_in = S_DADD;
            end
         end
         S_DADD: begin
            acc_in = ss[31:0];
            clamp_in = clamp_ff | ps[32] | ss[32] | cfix[32];
            if (step_ff == 3'd1) state_in = S_DIVSTART;
            else begin
               step_in = step_ff - 3'd1;
               state_in = S_DMUL;
            end
         end
         S_DIVSTART: begin
            o_idx_in = cnt_ff[5:0];
            if (acc_ff == '0) begin
               o_est_in = x_ff;
               o_st_in = ST_ZERO_DER;
               o_sat_in = clamp_ff;
               o_last_in = 1'b1;
               state_in = S_OUT;
            end else begin
               dabs = acc_ff[31] ? -acc_ff : acc_ff;
               dv_in = dabs;
               qneg_in = f_ff[31] ^ acc_ff[31];
               dq_in = 64'(f_ff[31] ? 32'(-f_ff) : 32'(f_ff)) << FRAC_BITS;
               if (f_ff == 32'sh80000000) dq_in = 64'h80000000 << FRAC_BITS;
               rem_in = '0;
               dcnt_in = CNT_W'(DIV_N);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!trial[64]) begin
               rem_in = trial[63:0];
               dq_in = {dq_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[62:0], dq_ff[63]};
               dq_in = {dq_ff[62:0], 1'b0};
            end
            dcnt_in = dcnt_ff - CNT_W'(1);
            if (dcnt_ff == CNT_W'(1)) state_in = S_QUOT;
         end
         S_QUOT: begin
            clamp_in = clamp_ff | qs[32] | nxs[32];
            o_est_in = nxs[31:0];
            state_in = S_STEP;
            f_in = 32'(stepmag);
         end
         S_STEP: begin
            o_sat_in = clamp_ff;
            if ({1'b0, f_ff} <= {2'b00, eps_ff}) begin
               o_st_in = ST_CONVERGED; o_last_in = 1'b1;
            end else if (cnt_ff + MAXI_W'(1) >= lim_ff) begin
               o_st_in = ST_LIMIT; o_last_in = 1'b1;
            end else begin
               o_st_in = ST_RUNNING; o_last_in = 1'b0;
            end
            state_in = S_OUT;
         end
         S_OUT: if (rsp_tready) begin
            x_in = o_est_ff;
            cnt_in = cnt_ff + MAXI_W'(1);
            step_in = 3'd4;
            state_in = o_last_ff ? S_IDLE : S_ITER;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         clamp_ff <= 1'b0;
         x_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         clamp_ff <= clamp_in;
         x_ff <= x_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; f_ff <= f_in; prod_ff <= prod_in; step_ff <= step_in;
      lim_ff <= lim_in; dq_ff <= dq_in; rem_ff <= rem_in; dv_ff <= dv_in;
      qneg_ff <= qneg_in; dcnt_ff <= dcnt_in; o_idx_ff <= o_idx_in;
      o_est_ff <= o_est_in; o_st_ff <= o_st_in; o_sat_ff <= o_sat_in;
      o_last_ff <= o_last_in;
   end
endmodule

// File: bench/tb_quartic_newton_root_finder.sv
// tb_quartic_newton_root_finder: self-checking bench for the quartic newton root finder
// depends on qnrf_pkg and quartic_newton_root_finder; predicts every iterate and compares
`timescale 1ns / 1ps
module tb_quartic_newton_root_finder;
   import qnrf_pkg::*;

   // register indexes not named in the package
   localparam logic [2:0] REG_COEF_0 = 3'd0;
   localparam logic [2:0] REG_COEF_1 = 3'd1;
   localparam logic [2:0] REG_COEF_2 = 3'd2;
   localparam logic [2:0] REG_COEF_3 = 3'd3;
   localparam int STALL_LIMIT = 20000;
   localparam int HOLD_OFF = 400;

   typedef struct packed {
      logic [5:0]  idx;
      logic [31:0] est;
      logic [1:0]  st;
      logic        sat;
      logic        fin;
   } iterate_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;       // start_guess
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;            // iteration_index[5:0], estimate[37:6], zero pad
   logic [2:0] rsp_tuser;             // status[1:0], saturated[2]
   logic rsp_tlast;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   quartic_newton_root_finder uut (.*);

   always #2 clock = ~clock;

   // bench copy of the register file
   logic signed [15:0] coef_r [5] = '{default: '0};
   logic [30:0] eps_r = 31'd66;
   logic [6:0] max_iter_r = 7'd64;

   logic [15:0] guess_q [$];          // requests waiting to be offered
   iterate_type iterate_q [$];        // iterates predicted but not yet seen
   bit calm = 0;                      // no idling in the closing phase
   bit failed = 0;
   int req_count = 0;
   int send_gap = 0;
   int stall_cycles = 0;

   // saturate to signed 32 bits, noting any clamp
   function automatic longint clip(input longint v, inout bit c);
      if (v > 64'sd2147483647) begin
         c = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         c = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // fixed-point product, arithmetic shift rounds toward minus infinity
   function automatic longint fx_product(input longint a, input longint b, inout bit c);
      return clip((a * b) >>> 16, c);
   endfunction

   // work out every iterate that one start guess should produce
   task automatic predict_iterates(input logic [15:0] g);
      bit clamp;
      bit fin;
      longint fc [5];
      longint dc [4];
      longint x, f, d, q, nx, diff;
      int lim, k, j;
      iterate_type r;
      clamp = 0;
      lim = max_iter_r;
      if (lim == 0) lim = 1;
      if (lim > 64) lim = 64;
      x = clip(longint'($signed(g)) * 65536, clamp);
      for (j = 0; j < 5; j++) fc[j] = clip(longint'(coef_r[j]) * 65536, clamp);
      dc[3] = clip(longint'(coef_r[4]) * 4 * 65536, clamp);
      dc[2] = clip(longint'(coef_r[3]) * 3 * 65536, clamp);
      dc[1] = clip(longint'(coef_r[2]) * 2 * 65536, clamp);
      dc[0] = fc[1];
      for (k = 0; k < lim; k++) begin
         f = fc[4];
         for (j = 3; j >= 0; j--) f = clip(fx_product(f, x, clamp) + fc[j], clamp);
         d = dc[3];
         for (j = 2; j >= 0; j--) d = clip(fx_product(d, x, clamp) + dc[j], clamp);
         if (d == 0) begin
            nx = x;
            r.st = ST_ZERO_DER;
            fin = 1;
         end else begin
            q = clip((f * 65536) / d, clamp);
            nx = clip(x - q, clamp);
            diff = (nx > x) ? nx - x : x - nx;
            fin = 1;
            if (diff <= longint'(eps_r)) r.st = ST_CONVERGED;
            else if (k + 1 >= lim) r.st = ST_LIMIT;
            else begin
               r.st = ST_RUNNING;
               fin = 0;
            end
         end
         r.idx = k[5:0];
         r.est = nx[31:0];
         r.sat = clamp;
         r.fin = fin;
         iterate_q.push_back(r);
         x = nx;
         if (fin) break;
      end
   endtask

   // driver: offers pending guesses, with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_iterates(req_tdata);
            req_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (guess_q.size() > 0) begin
               req_tdata <= guess_q.pop_front();
               req_tvalid <= 1'b1;
               if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 8);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver readiness: random stall bursts and one long hold-off
   int rsp_gap = 0;
   bit held = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (!held && req_count >= 30) begin
         held = 1;
         rsp_gap = HOLD_OFF;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_gap = $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: compare each accepted iterate with the oldest prediction
   always @(posedge clock) begin
      iterate_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (iterate_q.size() == 0) begin
            $error("unexpected iterate: index %0d estimate %h", rsp_tdata[5:0], rsp_tdata[37:6]);
            failed = 1;
         end else begin
            e = iterate_q.pop_front();
            if (rsp_tdata[5:0] !== e.idx) begin
               $error("iteration_index: expected %0d, got %0d", e.idx, rsp_tdata[5:0]);
               failed = 1;
            end
            if (rsp_tdata[37:6] !== e.est) begin
               $error("estimate: expected %h, got %h", e.est, rsp_tdata[37:6]);
               failed = 1;
            end
            if (rsp_tuser[1:0] !== e.st) begin
               $error("status: expected %0d, got %0d", e.st, rsp_tuser[1:0]);
               failed = 1;
            end
            if (rsp_tuser[2] !== e.sat) begin
               $error("saturated: expected %0d, got %0d", e.sat, rsp_tuser[2]);
               failed = 1;
            end
            if (rsp_tlast !== e.fin) begin
               $error("last: expected %0d, got %0d", e.fin, rsp_tlast);
               failed = 1;
            end
         end
      end
   end

   // watchdog: cycles with no handshake of any kind
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // apb write: setup cycle then access cycle; bench copy follows the bus
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_W'(idx) << 2;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx <= REG_COEF_4) coef_r[idx] = data[15:0];
      else if (idx == REG_EPSILON) eps_r = data[30:0];
      else if (idx == REG_MAX_ITER) max_iter_r = data[6:0];
   endtask

   // coefficients go in with random junk above bit 15
   task automatic set_poly(input int c4, input int c3, input int c2, input int c1, input int c0);
      csr_write(REG_COEF_4, {16'($urandom_range(0, 65535)), c4[15:0]});
      csr_write(REG_COEF_3, {16'($urandom_range(0, 65535)), c3[15:0]});
      csr_write(REG_COEF_2, {16'($urandom_range(0, 65535)), c2[15:0]});
      csr_write(REG_COEF_1, {16'($urandom_range(0, 65535)), c1[15:0]});
      csr_write(REG_COEF_0, {16'($urandom_range(0, 65535)), c0[15:0]});
   endtask

   // let every queued guess finish before registers change
   task automatic drain;
      while (guess_q.size() > 0 || req_tvalid || iterate_q.size() > 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   initial begin
      int p, n, a, b, c, d;
      bit quartic;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset registers: all-zero polynomial, derivative zero at once
      guess_q = '{16'h0000, 16'h7fff, 16'h8000};
      drain();

      // x^2 - 4, converging from either side; zero guess hits zero derivative
      set_poly(0, 0, 1, 0, -4);
      guess_q = '{16'd1, 16'd3, -16'sd1, -16'sd3, 16'd100, 16'd0};
      drain();

      // extreme coefficients saturate everything; limit of zero acts as one
      csr_write(REG_MAX_ITER, 32'h0);
      set_poly(32767, 32767, 32767, 32767, 32767);
      guess_q = '{16'h7fff, 16'h8000, 16'd5};
      drain();
      set_poly(-32768, -32768, -32768, -32768, -32768);
      guess_q = '{16'h7fff, 16'h8000, 16'd5};
      drain();

      // limit above range acts as the top limit; zero epsilon rarely converges
      csr_write(REG_MAX_ITER, 32'hffff_ff7f);
      csr_write(REG_EPSILON, 32'h0);
      set_poly(0, 0, 1, 0, -2);
      guess_q = '{16'd1, -16'sd1};
      drain();

      // widest epsilon converges after one step
      csr_write(REG_EPSILON, 32'hffff_ffff);
      guess_q = '{16'd7, -16'sd20, 16'h7fff};
      drain();

      // random phases: mostly polynomials with real integer roots
      for (p = 0; p < 11; p++) begin
         if (p == 10) calm = 1;
         quartic = $urandom_range(0, 1);
         if ($urandom_range(0, 9) < 7) begin
            a = $urandom_range(0, 8) - 4;
            b = $urandom_range(0, 8) - 4;
            c = $urandom_range(0, 8) - 4;
            d = $urandom_range(0, 8) - 4;
            if (quartic)
               set_poly(1, -(a + b + c + d), a*b + a*c + a*d + b*c + b*d + c*d,
                        -(a*b*c + a*b*d + a*c*d + b*c*d), a*b*c*d);
            else
               set_poly(0, 0, 1, -(a + b), a*b);
            csr_write(REG_EPSILON, {1'($urandom_range(0, 1)), 31'($urandom_range(0, 4000))});
            csr_write(REG_MAX_ITER, {25'($urandom), 7'($urandom_range(1, 24))});
         end else begin
            set_poly($urandom, $urandom, $urandom, $urandom, $urandom);
            csr_write(REG_EPSILON, $urandom);
            csr_write(REG_MAX_ITER, {25'($urandom), 7'($urandom_range(0, 12))});
         end
         for (n = 0; n < 28; n++) begin
            if ($urandom_range(0, 3) == 0) guess_q.push_back(16'($urandom));
            else guess_q.push_back(16'($urandom_range(0, 40) - 20));
         end
         drain();
      end

      if (!failed && iterate_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
